/* rtl/core/rrqs_pkg.sv */
`default_nettype none

package rrqs_pkg;

    // Default sizes for the top-level parameters
    localparam int DEF_SLOTS          = 64;
    localparam int DEF_MAX_QUEUES     = 8;
    localparam int DEF_DEVICE_ID_BITS = 16;

    // Fixed field widths
    localparam int CNT_W    = 32;   // per-slot round-robin counter
    localparam int DIGIT_W  = 4;    // counter bits retired per modulo step
    localparam int CPU_W    = 10;   // cpus register
    localparam int STATUS_W = 2;
    localparam int QIDX_W   = 3;
    localparam int SIDX_W   = 6;
    localparam int OUT_W    = 16;   // result beat, padded to whole bytes

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic                load_id;
        logic                scan_start;
        logic                mod_start;
        logic                commit;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } rrqs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic id_zero;
        logic scan_done;
        logic slot_ok;
        logic mod_done;
    } rrqs_stat_t;

endpackage

`default_nettype wire

/* rtl/core/rrqs_mod.sv */
`default_nettype none

module rrqs_mod
    import rrqs_pkg::*;
#(
    parameter int MAX_QUEUES = DEF_MAX_QUEUES,
    localparam int QC_W = $clog2(MAX_QUEUES + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [CNT_W-1:0] dividend,
    input  wire logic [QC_W-1:0]  divisor,
    output logic                  done,
    output logic [QC_W-1:0]       remainder
);

    localparam int STEPS  = CNT_W / DIGIT_W;
    localparam int STEP_W = $clog2(STEPS);

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  shift_reg;
    logic [QC_W-1:0]   rem_reg;
    logic [QC_W-1:0]   div_reg;
    logic [QC_W-1:0]   rem_next;
    logic [QC_W-1:0]   r;
    logic [QC_W:0]     t;

    // Retire DIGIT_W dividend bits per cycle, restoring style, MSB first
    always_comb begin
        r = rem_reg;
        t = '0;
        for (int k = 0; k < DIGIT_W; k++) begin
            t = {r, shift_reg[CNT_W-1-k]};
            if (t >= {1'b0, div_reg}) begin
                t = t - {1'b0, div_reg};
            end
            r = t[QC_W-1:0];
        end
        rem_next = r;
    end

    // Step sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end else if (run_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            // treat a zero queue count as one
            div_reg   <= (divisor == '0) ? QC_W'(1) : divisor;
        end else if (run_reg) begin
            shift_reg <= {shift_reg[CNT_W-DIGIT_W-1:0], DIGIT_W'(0)};
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/core/rrqs_datapath.sv */
`default_nettype none

module rrqs_datapath
    import rrqs_pkg::*;
#(
    parameter int SLOTS          = DEF_SLOTS,
    parameter int MAX_QUEUES     = DEF_MAX_QUEUES,
    parameter int DEVICE_ID_BITS = DEF_DEVICE_ID_BITS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [DEVICE_ID_BITS-1:0] dev_id,
    input  wire logic                      cfg_we,
    input  wire logic [CPU_W-1:0]          cfg_data,
    input  wire rrqs_cmd_t                 cmd,
    output rrqs_stat_t                     stat,
    output logic [OUT_W-1:0]               out_data
);

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QC_W    = $clog2(MAX_QUEUES + 1);
    localparam int ID_W    = DEVICE_ID_BITS;
    localparam int ENTRY_W = CNT_W + QC_W + ID_W;

    // Slot table: {counter, queue count, device id}
    logic [ENTRY_W-1:0] mem [SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [SLOTS-1:0]   used_reg;

    logic [CPU_W-1:0]  cpus_reg;
    logic [ID_W-1:0]   id_reg;

    logic              rd_run_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic              cmp_valid_reg;
    logic [SLOT_W-1:0] cmp_idx_reg;
    logic              scan_done_reg;

    logic              found_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic [CNT_W-1:0]  hold_cnt_reg;
    logic [QC_W-1:0]   hold_qc_reg;
    logic              free_reg;
    logic [SLOT_W-1:0] free_idx_reg;

    logic [SLOT_W-1:0] work_slot_reg;
    logic [CNT_W-1:0]  work_cnt_reg;
    logic [QC_W-1:0]   work_qc_reg;
    logic [OUT_W-1:0]  out_reg;

    logic [QC_W-1:0]   clamp_qc;
    logic [SLOT_W-1:0] sel_slot;
    logic [CNT_W-1:0]  sel_cnt;
    logic [QC_W-1:0]   sel_qc;
    logic              mod_done;
    logic [QC_W-1:0]   mod_rem;
    logic [CNT_W-1:0]  q_ext;
    logic [CNT_W-1:0]  s_ext;
    logic [QIDX_W-1:0] q_field;
    logic [SIDX_W-1:0] s_field;
    logic              cmp_used;
    logic [ID_W-1:0]   cmp_dev;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpus_reg <= CPU_W'(1);
        end else if (cfg_we) begin
            cpus_reg <= cfg_data;
        end
    end

    // Latch the request id
    always_ff @(posedge aclk) begin
        if (cmd.load_id) begin
            id_reg <= dev_id;
        end
    end

    // Table memory: one read port for the scan, one write port for commit
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            mem[work_slot_reg] <= {work_cnt_reg + CNT_W'(1), work_qc_reg, id_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_run_reg) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // Slot occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (cmd.commit) begin
            used_reg[work_slot_reg] <= 1'b1;
        end
    end

    // Scan address sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_run_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            scan_done_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= rd_run_reg;
            cmp_idx_reg   <= rd_idx_reg;
            scan_done_reg <= cmp_valid_reg && (cmp_idx_reg == SLOT_W'(SLOTS - 1));
            if (cmd.scan_start) begin
                rd_run_reg <= 1'b1;
                rd_idx_reg <= '0;
            end else if (rd_run_reg) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                if (rd_idx_reg == SLOT_W'(SLOTS - 1)) begin
                    rd_run_reg <= 1'b0;
                end
            end
        end
    end

    assign cmp_used = used_reg[cmp_idx_reg];
    assign cmp_dev  = rd_data_reg[ID_W-1:0];

    // Compare each slot read: record the matching slot and the lowest free one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end else if (cmd.scan_start) begin
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end else if (cmp_valid_reg) begin
            if (cmp_used && (cmp_dev == id_reg) && !found_reg) begin
                found_reg <= 1'b1;
            end
            if (!cmp_used && !free_reg) begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_valid_reg && cmp_used && (cmp_dev == id_reg) && !found_reg) begin
            hit_idx_reg  <= cmp_idx_reg;
            hold_cnt_reg <= rd_data_reg[ENTRY_W-1 -: CNT_W];
            hold_qc_reg  <= rd_data_reg[ID_W +: QC_W];
        end
        if (cmp_valid_reg && !cmp_used && !free_reg) begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    // Queue count of a newly claimed slot: zero counts as one, cap at MAX_QUEUES
    always_comb begin
        if (cpus_reg == '0) begin
            clamp_qc = QC_W'(1);
        end else if (cpus_reg > CPU_W'(MAX_QUEUES)) begin
            clamp_qc = QC_W'(MAX_QUEUES);
        end else begin
            clamp_qc = QC_W'(cpus_reg);
        end
    end

    // Pick the existing slot or a fresh one
    assign sel_slot = found_reg ? hit_idx_reg  : free_idx_reg;
    assign sel_cnt  = found_reg ? hold_cnt_reg : '0;
    assign sel_qc   = found_reg ? hold_qc_reg  : clamp_qc;

    always_ff @(posedge aclk) begin
        if (cmd.mod_start) begin
            work_slot_reg <= sel_slot;
            work_cnt_reg  <= sel_cnt;
            work_qc_reg   <= sel_qc;
        end
    end

    rrqs_mod #(
        .MAX_QUEUES (MAX_QUEUES)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (sel_cnt),
        .divisor   (sel_qc),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Result beat: fields other than status are zero unless ok
    assign q_ext   = CNT_W'(mod_rem);
    assign s_ext   = CNT_W'(work_slot_reg);
    assign q_field = (cmd.status == ST_OK) ? q_ext[QIDX_W-1:0] : '0;
    assign s_field = (cmd.status == ST_OK) ? s_ext[SIDX_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= OUT_W'({s_field, q_field, cmd.status});
        end
    end

    assign out_data = out_reg;

    assign stat.id_zero   = (id_reg == '0);
    assign stat.scan_done = scan_done_reg;
    assign stat.slot_ok   = found_reg || free_reg;
    assign stat.mod_done  = mod_done;

endmodule

`default_nettype wire

/* rtl/core/rrqs_ctrl.sv */
`default_nettype none

module rrqs_ctrl
    import rrqs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire rrqs_stat_t stat,
    output rrqs_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        s_tready       = 1'b0;
        cmd.load_id    = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.mod_start  = 1'b0;
        cmd.commit     = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.status     = status_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_id = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.id_zero) begin
                    status_next = ST_BAD_ID;
                    state_next  = S_OUT;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.scan_done) begin
                    if (stat.slot_ok) begin
                        cmd.mod_start = 1'b1;
                        state_next    = S_MOD;
                    end else begin
                        status_next = ST_FULL;
                        state_next  = S_OUT;
                    end
                end
            end
            S_MOD: begin
                if (stat.mod_done) begin
                    cmd.commit  = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_OUT;
                end
            end
            S_OUT: begin
                // load the output register once it is empty or being drained
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop when the beat is taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            status_reg   <= ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

/* rtl/core/per_device_round_robin_queue_select.sv */
`default_nettype none

// Channel     Dir  Handshake            Payload
// s_  input   in   s_tvalid/s_tready    s_tdata: dev_id
// m_  result  out  m_tvalid/m_tready    m_tdata: status, queue_index, slot_index
// cfg write   in   cfg_valid/cfg_ready  cfg_data: cpus
//
// One request at a time: the table scan reads one slot per cycle from the
// slot memory, then the counter modulo retires 4 bits per cycle.
// A zero device id skips the table scan and the modulo.
// Reset clears the slot occupancy bits at once; no clearing pass.
// A finished result waits in the output register while the next request
// is accepted; a stalled m_ side holds the block before its result load.

module per_device_round_robin_queue_select
    import rrqs_pkg::*;
#(
    parameter int SLOTS          = DEF_SLOTS,
    parameter int MAX_QUEUES     = DEF_MAX_QUEUES,
    parameter int DEVICE_ID_BITS = DEF_DEVICE_ID_BITS,
    localparam int IN_W = ((DEVICE_ID_BITS + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // dev_id, zero padded
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // status[1:0], queue_index[4:2],
                                             // slot_index[10:5], zero padded
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CPU_W-1:0] cfg_data   // cpus
);

    rrqs_cmd_t  cmd;
    rrqs_stat_t stat;

    assign cfg_ready = 1'b1;

    rrqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrqs_datapath #(
        .SLOTS          (SLOTS),
        .MAX_QUEUES     (MAX_QUEUES),
        .DEVICE_ID_BITS (DEVICE_ID_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dev_id    (s_tdata[DEVICE_ID_BITS-1:0]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

/* rtl/core/rrqs_check.sv */
`default_nettype none

module rrqs_check
    import rrqs_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // One request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

    // Status is one of the defined codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_BAD_ID ||
                      m_tdata[1:0] == ST_FULL))
        else $error("undefined status code");

    // Rejected requests carry zero queue and slot fields
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[OUT_W-1:2] == '0))
        else $error("rejected result has nonzero fields");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind per_device_round_robin_queue_select rrqs_check u_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import rrqs_pkg::*;

    localparam int SLOT_COUNT  = 64;
    localparam int QUEUE_LIMIT = 8;
    localparam int ID_W        = 16;

    // One predicted routing decision
    typedef struct {
        logic [ID_W-1:0]     dev_id;
        logic [STATUS_W-1:0] status;
        logic [QIDX_W-1:0]   queue_index;
        logic [SIDX_W-1:0]   slot_index;
    } route_t;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [ID_W-1:0]   s_tdata   = '0;     // dev_id[15:0]
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;            // status[1:0], queue_index[4:2], slot_index[10:5]
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CPU_W-1:0]  cfg_data  = '0;     // cpus

    // Shadow copy of the slot table and the cpus register
    bit                slot_taken  [SLOT_COUNT];
    logic [ID_W-1:0]   slot_owner  [SLOT_COUNT];
    logic [3:0]        slot_queues [SLOT_COUNT];
    logic [31:0]       slot_count  [SLOT_COUNT];
    logic [CPU_W-1:0]  cpus_setting = 10'd1;
    int                slots_claimed = 0;
    bit                claimed_ids [logic [ID_W-1:0]];
    logic [ID_W-1:0]   claimed_list [$];

    route_t            pending_routes [$];
    int                mismatch_count = 0;
    bit                steady_flow    = 1'b0;

    per_device_round_robin_queue_select u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Look up or claim the device's slot and advance its round-robin counter
    function automatic route_t route_request(input logic [ID_W-1:0] id);
        route_t           r;
        int               hit;
        int               open_slot;
        logic [CPU_W-1:0] n;
        logic [3:0]       qc;
        logic [31:0]      sel;
        r.dev_id      = id;
        r.status      = ST_OK;
        r.queue_index = '0;
        r.slot_index  = '0;
        hit           = -1;
        open_slot     = -1;
        if (id == '0) begin
            r.status = ST_BAD_ID;
            return r;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_taken[i] && slot_owner[i] == id) begin
                hit = i;
                break;
            end
            if (!slot_taken[i] && open_slot < 0)
                open_slot = i;
        end
        if (hit < 0) begin
            if (open_slot < 0) begin
                r.status = ST_FULL;
                return r;
            end
            // claim the lowest free slot; queue count frozen from cpus now
            hit = open_slot;
            n   = cpus_setting;
            if (n == '0)
                n = 10'd1;
            if (n > QUEUE_LIMIT)
                n = CPU_W'(QUEUE_LIMIT);
            slot_taken[hit]  = 1'b1;
            slot_owner[hit]  = id;
            slot_queues[hit] = n[3:0];
            slot_count[hit]  = '0;
            slots_claimed++;
            claimed_ids[id]  = 1'b1;
            claimed_list.push_back(id);
        end
        qc = (slot_queues[hit] == '0) ? 4'd1 : slot_queues[hit];
        sel = slot_count[hit] % {28'd0, qc};
        slot_count[hit] = slot_count[hit] + 32'd1;
        r.queue_index = sel[QIDX_W-1:0];
        r.slot_index  = hit[SIDX_W-1:0];
        return r;
    endfunction

    // Mostly short gaps, a few long ones, none in a steady stretch
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one request beat and record its expected route
    task automatic send_request(input logic [ID_W-1:0] id);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_routes.push_back(route_request(id));
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= ID_W'($urandom);
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drain all results, then write the cpus register
    task automatic write_cpus(input logic [CPU_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_routes.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cpus_setting = value;
        cfg_valid <= 1'b0;
        cfg_data  <= CPU_W'($urandom);
    endtask

    task automatic report_mismatch(input string what, input route_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t mismatch (%s) id=%h: exp st=%0d q=%0d slot=%0d, ",
                      "got st=%0d q=%0d slot=%0d"},
                     $realtime, what, want.dev_id, want.status, want.queue_index,
                     want.slot_index, m_tdata[1:0], m_tdata[4:2], m_tdata[10:5]);
    endtask

    // Check every result beat against the oldest expected route
    always @(posedge aclk) begin
        route_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_routes.size() == 0) begin
                want = '{default: '0};
                report_mismatch("result with nothing pending", want);
            end else begin
                want = pending_routes.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status field", want);
                else if (m_tdata[4:2] !== want.queue_index)
                    report_mismatch("queue_index field", want);
                else if (m_tdata[10:5] !== want.slot_index)
                    report_mismatch("slot_index field", want);
            end
        end
    end

    // Random backpressure on the result side
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap();
                m_tready <= (stall_left == 0);
            end
        end
    end

    // Zero id, extreme ids, first claims and repeat hits at the reset cpus value
    task automatic test_directed_ids();
        send_request(16'h0000);
        send_request(16'hFFFF);
        send_request(16'hFFFF);
        send_request(16'h0001);
        send_request(16'h0000);
        send_request(16'h8000);
        send_request(16'h5555);
        send_request(16'hAAAA);
        send_request(16'h0001);
    endtask

    // Zero cpus gives one queue; a huge value is clamped to eight
    task automatic test_queue_clamp();
        write_cpus(10'd0);
        repeat (3) send_request(16'h0002);
        write_cpus(10'd1023);
        repeat (10) send_request(16'h0003);
    endtask

    // Mostly hits on claimed devices, some new devices (more once the table is full), some zero ids
    task automatic test_random_traffic();
        int              cpu_plan [11] = '{2, 3, 4, 5, 6, 7, 8, 9, 0, 1023, 1};
        int              roll;
        int              new_rate;
        logic [ID_W-1:0] id;
        for (int phase = 0; phase < 13; phase++) begin
            write_cpus(phase < 11 ? CPU_W'(cpu_plan[phase])
                                  : CPU_W'($urandom_range(0, 1023)));
            steady_flow = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 100; n++) begin
                roll     = $urandom_range(0, 99);
                new_rate = (slots_claimed < SLOT_COUNT) ? 6 : 15;
                if (roll < 8) begin
                    id = '0;
                end else if (roll < 8 + new_rate || claimed_list.size() == 0) begin
                    do
                        id = ID_W'($urandom_range(1, 65535));
                    while (claimed_ids.exists(id));
                end else begin
                    id = claimed_list[$urandom_range(0, claimed_list.size() - 1)];
                end
                send_request(id);
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_ids();
        test_queue_clamp();
        test_random_traffic();
        // drain outstanding results
        s_tvalid <= 1'b0;
        while (pending_routes.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

endmodule
